// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the flash command sequencer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define SFCS_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset
`define SFCS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- rtl/sfcs_pkg.sv -----
// ----------------------------------------------------------------------------
// sfcs_pkg
// Types and constants shared by the SPI flash command sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcs_pkg;

   // Request operation codes
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_PROGRAM = 2'd2;
   localparam logic [1:0] OP_ERASE   = 2'd3;

   // Flash command bytes
   localparam logic [7:0] CMD_READ         = 8'h03;
   localparam logic [7:0] CMD_WRITE_ENABLE = 8'h06;
   localparam logic [7:0] CMD_PROGRAM      = 8'h02;
   localparam logic [7:0] CMD_ERASE        = 8'hd8;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 24;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROGRAM_WAIT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERASE_WAIT   = 1'd1;

   // Configuration reset values
   localparam logic [15:0] PROGRAM_WAIT_RESET = 16'd100;
   localparam logic [23:0] ERASE_WAIT_RESET   = 24'd7500000;

   // Transaction segments, one-hot
   typedef enum logic [9:0] {
      SEG_IDLE     = 10'b00_0000_0001,
      SEG_WEN_HI   = 10'b00_0000_0010,
      SEG_WEN_LO   = 10'b00_0000_0100,
      SEG_WEN_BITS = 10'b00_0000_1000,
      SEG_WEN_END  = 10'b00_0001_0000,
      SEG_HI       = 10'b00_0010_0000,
      SEG_LO       = 10'b00_0100_0000,
      SEG_BITS     = 10'b00_1000_0000,
      SEG_END      = 10'b01_0000_0000,
      SEG_WAIT     = 10'b10_0000_0000
   } segment_type;

   // Configuration write bundle
   typedef struct packed {
      logic                   we;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
   } csr_write_type;

   // One phase result
   typedef struct packed {
      logic       rejected;
      logic [7:0] read_data;
      logic       read_valid;
      logic       busy_res;
      logic       sclk;
      logic       mosi;
      logic       chip_select_n;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/sfcs_engine.sv -----
// ----------------------------------------------------------------------------
// sfcs_engine
// Phase sequencer state, configuration registers and one-phase step logic.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcs_engine #(
   parameter int ADDR_BYTES = 3
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    step,
   input  wire  [1:0]             operation,
   input  wire  [23:0]            address,
   input  wire  [7:0]             write_data,
   input  wire                    miso,
   input  wire sfcs_pkg::csr_write_type csr,
   output sfcs_pkg::result_type   result
);

   localparam logic [2:0] AddrBytesW = 3'(ADDR_BYTES);

   // State registers
   sfcs_pkg::segment_type seg_ff, seg_in;
   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  bit_ff, bit_in;
   logic [2:0]  byte_ff, byte_in;
   logic [7:0]  out_shift_ff, out_shift_in;
   logic [7:0]  in_shift_ff, in_shift_in;
   logic [1:0]  held_op_ff, held_op_in;
   logic [23:0] held_addr_ff, held_addr_in;
   logic [7:0]  held_data_ff, held_data_in;
   logic [23:0] wait_ff, wait_in;
   logic [15:0] prog_wait_ff, prog_wait_in;
   logic [23:0] erase_wait_ff, erase_wait_in;

   // Step scratch
   sfcs_pkg::segment_type seg_eff;
   logic        idle_like;
   logic [2:0]  byte_count;
   logic [2:0]  byte_next;
   logic [23:0] wait_sel;
   logic [23:0] wait_dec;

   // Byte k of the main transfer: opcode, address MSB first, data or dummy
   function automatic logic [7:0] byte_at(input logic [2:0] k, input logic [1:0] op,
                                          input logic [23:0] addr, input logic [7:0] data);
      logic [7:0] b;
      logic [2:0] idx;
      idx = AddrBytesW - k;
      b = 8'h00;
      if (k == 3'd0) begin
         if (op == sfcs_pkg::OP_READ) b = sfcs_pkg::CMD_READ;
         else if (op == sfcs_pkg::OP_PROGRAM) b = sfcs_pkg::CMD_PROGRAM;
         else b = sfcs_pkg::CMD_ERASE;
      end else if (k <= AddrBytesW) begin
         unique case (idx)
            3'd0: b = addr[7:0];
            3'd1: b = addr[15:8];
            3'd2: b = addr[23:16];
            default: b = 8'h00;
         endcase
      end else if (op == sfcs_pkg::OP_PROGRAM) begin
         b = data;
      end
      return b;
   endfunction

   // Classify current segment; unknown codes act as idle
   always_comb begin
      unique case (seg_ff)
         sfcs_pkg::SEG_WEN_HI, sfcs_pkg::SEG_WEN_LO, sfcs_pkg::SEG_WEN_BITS,
         sfcs_pkg::SEG_WEN_END, sfcs_pkg::SEG_HI, sfcs_pkg::SEG_LO,
         sfcs_pkg::SEG_BITS, sfcs_pkg::SEG_END, sfcs_pkg::SEG_WAIT: idle_like = 1'b0;
         default: idle_like = 1'b1;
      endcase
   end

   assign byte_count = 3'd1 + AddrBytesW + ((held_op_ff == sfcs_pkg::OP_ERASE) ? 3'd0 : 3'd1);
   assign byte_next  = byte_ff + 3'd1;
   assign wait_sel   = (held_op_ff == sfcs_pkg::OP_PROGRAM) ? {8'd0, prog_wait_ff}
                                                            : erase_wait_ff;
   assign wait_dec   = (wait_ff != 24'd0) ? wait_ff - 24'd1 : wait_ff;

   // One phase of the sequencer
   always_comb begin
      seg_in       = seg_ff;
      phase_in     = phase_ff;
      bit_in       = bit_ff;
      byte_in      = byte_ff;
      out_shift_in = out_shift_ff;
      in_shift_in  = in_shift_ff;
      held_op_in   = held_op_ff;
      held_addr_in = held_addr_ff;
      held_data_in = held_data_ff;
      wait_in      = wait_ff;
      seg_eff      = seg_ff;

      result.chip_select_n = 1'b1;
      result.mosi          = 1'b0;
      result.sclk          = 1'b0;
      result.busy_res      = 1'b1;
      result.read_valid    = 1'b0;
      result.read_data     = 8'h00;
      result.rejected      = 1'b0;

      // Accept a command when idle, flag it when busy
      if (idle_like) begin
         seg_eff = sfcs_pkg::SEG_IDLE;
         if (operation != sfcs_pkg::OP_TICK) begin
            held_op_in   = operation;
            held_addr_in = address;
            held_data_in = write_data;
            seg_eff = (operation == sfcs_pkg::OP_READ) ? sfcs_pkg::SEG_HI
                                                       : sfcs_pkg::SEG_WEN_HI;
         end
      end else if (operation != sfcs_pkg::OP_TICK) begin
         result.rejected = 1'b1;
      end

      seg_in = seg_eff;
      unique case (seg_eff)
         sfcs_pkg::SEG_WEN_HI: seg_in = sfcs_pkg::SEG_WEN_LO;
         sfcs_pkg::SEG_HI:     seg_in = sfcs_pkg::SEG_LO;
         sfcs_pkg::SEG_WEN_LO, sfcs_pkg::SEG_LO: begin
            result.chip_select_n = 1'b0;
            phase_in = 2'd0;
            bit_in   = 3'd0;
            byte_in  = 3'd0;
            if (seg_eff == sfcs_pkg::SEG_LO) begin
               out_shift_in = byte_at(3'd0, held_op_ff, held_addr_ff, held_data_ff);
               seg_in       = sfcs_pkg::SEG_BITS;
            end else begin
               out_shift_in = sfcs_pkg::CMD_WRITE_ENABLE;
               seg_in       = sfcs_pkg::SEG_WEN_BITS;
            end
         end
         sfcs_pkg::SEG_WEN_BITS, sfcs_pkg::SEG_BITS: begin
            result.chip_select_n = 1'b0;
            result.mosi = out_shift_ff[~bit_ff];
            result.sclk = (phase_ff == 2'd1);
            if (phase_ff == 2'd1) in_shift_in = {in_shift_ff[6:0], miso};
            if (phase_ff < 2'd2) begin
               phase_in = phase_ff + 2'd1;
            end else begin
               phase_in = 2'd0;
               if (bit_ff != 3'd7) begin
                  bit_in = bit_ff + 3'd1;
               end else begin
                  bit_in  = 3'd0;
                  byte_in = byte_next;
                  // Close the transfer after its last byte, else load the next one
                  if (seg_eff == sfcs_pkg::SEG_WEN_BITS) begin
                     if (byte_next >= 3'd1) seg_in = sfcs_pkg::SEG_WEN_END;
                     else out_shift_in = sfcs_pkg::CMD_WRITE_ENABLE;
                  end else begin
                     if (byte_next >= byte_count) seg_in = sfcs_pkg::SEG_END;
                     else out_shift_in = byte_at(byte_next, held_op_ff, held_addr_ff,
                                                 held_data_ff);
                  end
               end
            end
         end
         sfcs_pkg::SEG_WEN_END: seg_in = sfcs_pkg::SEG_HI;
         sfcs_pkg::SEG_END: begin
            if (held_op_ff == sfcs_pkg::OP_READ) begin
               result.read_valid = 1'b1;
               result.read_data  = in_shift_ff;
               seg_in = sfcs_pkg::SEG_IDLE;
            end else if (wait_sel == 24'd0) begin
               seg_in = sfcs_pkg::SEG_IDLE;
            end else begin
               wait_in = wait_sel;
               seg_in  = sfcs_pkg::SEG_WAIT;
            end
         end
         sfcs_pkg::SEG_WAIT: begin
            wait_in = wait_dec;
            if (wait_dec == 24'd0) seg_in = sfcs_pkg::SEG_IDLE;
         end
         default: begin
            result.busy_res = 1'b0;
            seg_in = sfcs_pkg::SEG_IDLE;
         end
      endcase
   end

   // Configuration writes
   always_comb begin
      prog_wait_in  = prog_wait_ff;
      erase_wait_in = erase_wait_ff;
      if (csr.we) begin
         unique case (csr.index)
            sfcs_pkg::CSR_PROGRAM_WAIT: prog_wait_in  = csr.wdata[15:0];
            sfcs_pkg::CSR_ERASE_WAIT:   erase_wait_in = csr.wdata;
            default: ;
         endcase
      end
   end

   // Advance sequencer state on each accepted phase; configuration registers load on any write
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff        <= sfcs_pkg::SEG_IDLE;
         phase_ff      <= 2'd0;
         bit_ff        <= 3'd0;
         byte_ff       <= 3'd0;
         out_shift_ff  <= 8'h00;
         in_shift_ff   <= 8'h00;
         held_op_ff    <= 2'd0;
         held_addr_ff  <= 24'd0;
         held_data_ff  <= 8'h00;
         wait_ff       <= 24'd0;
         prog_wait_ff  <= sfcs_pkg::PROGRAM_WAIT_RESET;
         erase_wait_ff <= sfcs_pkg::ERASE_WAIT_RESET;
      end else begin
         prog_wait_ff  <= prog_wait_in;
         erase_wait_ff <= erase_wait_in;
         if (step) begin
            seg_ff       <= seg_in;
            phase_ff     <= phase_in;
            bit_ff       <= bit_in;
            byte_ff      <= byte_in;
            out_shift_ff <= out_shift_in;
            in_shift_ff  <= in_shift_in;
            held_op_ff   <= held_op_in;
            held_addr_ff <= held_addr_in;
            held_data_ff <= held_data_in;
            wait_ff      <= wait_in;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/sfcs_rsp_stage.sv -----
// ----------------------------------------------------------------------------
// sfcs_rsp_stage
// Result register with stream handshake; frees input side when drained.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcs_rsp_stage (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  load,
   input  wire sfcs_pkg::result_type result_in,
   output logic                 can_load,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output sfcs_pkg::result_type result_out
);

   logic                 valid_ff, valid_in;
   sfcs_pkg::result_type data_ff, data_in;

   // Take a new result when empty or when the held one transfers now
   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result_in;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign result_out = data_ff;

endmodule

`default_nettype wire

// ----- rtl/spi_flash_command_sequencer.sv -----
// ----------------------------------------------------------------------------
// spi_flash_command_sequencer
// SPI mode-0 flash master stepped one pin phase per request transfer.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  req_*   | in        | tuser: operation; tdata: address, write_data, miso
//  rsp_*   | out       | tuser: read_valid; tdata: pins, busy, read_data, rejected
//  csr_*   | in        | write enable, register index, write data
//
//  Each request transfer yields exactly one response, registered in the cycle
//  after the transfer; one phase per cycle while rsp_tready stays high, set by
//  the single step logic between sequencer state and response register.
//  Reset is synchronous and returns the sequencer to idle with default waits.
//  A stalled response holds req_tready low until it transfers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spi_flash_command_sequencer #(
   parameter int ADDR_BYTES = 3
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // address[23:0], write_data[31:24], miso[32], zero pad
   input  wire  [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // chip_select_n[0], mosi[1], sclk[2], busy_res[3],
                                    // read_data[11:4], rejected[12], zero pad
   output logic [0:0]  rsp_tuser,   // read_valid[0]
   input  wire         csr_we,
   input  wire  [sfcs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire  [sfcs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic                    step;
   sfcs_pkg::csr_write_type csr;
   sfcs_pkg::result_type    step_result;
   sfcs_pkg::result_type    rsp_result;

   assign step      = req_tvalid && req_tready;
   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   // Sequencer state and phase step
   sfcs_engine #(
      .ADDR_BYTES(ADDR_BYTES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .operation  (req_tuser),
      .address    (req_tdata[23:0]),
      .write_data (req_tdata[31:24]),
      .miso       (req_tdata[32]),
      .csr        (csr),
      .result     (step_result)
   );

   // Response register
   sfcs_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .result_in  (step_result),
      .can_load   (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .result_out (rsp_result)
   );

   // Pack response fields
   assign rsp_tdata = {3'b000, rsp_result.rejected, rsp_result.read_data,
                       rsp_result.busy_res, rsp_result.sclk, rsp_result.mosi,
                       rsp_result.chip_select_n};
   assign rsp_tuser = rsp_result.read_valid;

   // Checks
   `SFCS_ASSERT_NEXT(a_step_gives_result, clock, reset, step, rsp_tvalid,
                     "accepted phase produced no response")
   `SFCS_ASSERT_IMPLY(a_sclk_needs_cs, clock, reset, rsp_tvalid && rsp_tdata[2],
                      !rsp_tdata[0], "sclk high with chip select released")
   `SFCS_ASSERT_IMPLY(a_read_in_close, clock, reset, rsp_tvalid && rsp_tuser[0],
                      rsp_tdata[0] && rsp_tdata[3], "read completion outside closing phase")
   `SFCS_ASSERT_IMPLY(a_reject_when_busy, clock, reset, rsp_tvalid && rsp_tdata[12],
                      rsp_tdata[3], "command rejected while idle")

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SPI flash command sequencer. Pin phases are
// streamed in through the request channel, and a cycle-level model of the
// sequencer predicts the pin levels, busy, read data and reject flag of each
// phase. Every response transfer is checked against the oldest prediction.
// The sender runs in random bursts and the receiver stalls on its own
// pattern. Wait registers go through reset, zero, maximum, over-wide and
// random values.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   localparam int FLASH_ADDR_BYTES = 3;
   localparam int RANDOM_ROUNDS    = 2;
   localparam int ROUND_PHASES     = 60;

   typedef struct packed {
      logic [1:0]  op;
      logic [23:0] addr;
      logic [7:0]  data;
      logic        miso;
   } phase_item_type;

   logic clock;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // address[23:0], write_data[31:24], miso[32], zero pad
   logic [1:0]  req_tuser  = sfcs_pkg::OP_TICK;   // operation[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;   // chip_select_n[0], mosi[1], sclk[2], busy_res[3],
                             // read_data[11:4], rejected[12], zero pad
   logic [0:0]  rsp_tuser;   // read_valid[0]
   logic                             csr_we    = 1'b0;
   logic [sfcs_pkg::CSR_INDEX_W-1:0] csr_index = sfcs_pkg::CSR_PROGRAM_WAIT;
   logic [sfcs_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   spi_flash_command_sequencer #(
      .ADDR_BYTES(FLASH_ADDR_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Sequencer model state
   sfcs_pkg::segment_type seg_now = sfcs_pkg::SEG_IDLE;
   logic [1:0]  bit_phase  = '0;
   logic [2:0]  bit_no     = '0;
   logic [2:0]  byte_no    = '0;
   logic [7:0]  tx_byte    = '0;
   logic [7:0]  rx_byte    = '0;
   logic [1:0]  cmd_op     = sfcs_pkg::OP_TICK;
   logic [23:0] cmd_addr   = '0;
   logic [7:0]  cmd_data   = '0;
   logic [23:0] wait_left  = '0;
   logic [15:0] cfg_program_wait = sfcs_pkg::PROGRAM_WAIT_RESET;
   logic [23:0] cfg_erase_wait   = sfcs_pkg::ERASE_WAIT_RESET;

   phase_item_type        pending_phases[$];
   sfcs_pkg::result_type  expected_pins[$];

   phase_item_type        next_item;
   sfcs_pkg::result_type  want;
   bit          req_done  = 1'b0;
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;
   int unsigned stall_age  = 0;
   logic [15:0] stall_pattern = '1;

   int unsigned mismatch_count   = 0;
   int unsigned phases_run       = 0;
   int unsigned reads_done       = 0;
   int unsigned programs_started = 0;
   int unsigned erases_started   = 0;
   int unsigned rejects_seen     = 0;

   // Byte k of the main command frame: opcode, address MSB first, then data or dummy
   function automatic logic [7:0] frame_byte(logic [2:0] k);
      int shift;
      if (k == 0) begin
         case (cmd_op)
            sfcs_pkg::OP_READ:    return sfcs_pkg::CMD_READ;
            sfcs_pkg::OP_PROGRAM: return sfcs_pkg::CMD_PROGRAM;
            default:              return sfcs_pkg::CMD_ERASE;
         endcase
      end
      if (k <= FLASH_ADDR_BYTES) begin
         shift = 8 * (FLASH_ADDR_BYTES - k);
         if (shift >= 24) return 8'h00;
         return 8'(cmd_addr >> shift);
      end
      return (cmd_op == sfcs_pkg::OP_PROGRAM) ? cmd_data : 8'h00;
   endfunction

   // Advance the sequencer model by one phase and return its pin levels
   function automatic sfcs_pkg::result_type advance_phase(logic [1:0] op, logic [23:0] addr,
                                                          logic [7:0] data, logic miso);
      sfcs_pkg::result_type r;
      int unsigned n_bytes;
      logic [23:0] w;
      r = '0;
      r.chip_select_n = 1'b1;
      r.busy_res = 1'b1;
      phases_run++;

      // Accept a command only when idle
      if (seg_now == sfcs_pkg::SEG_IDLE) begin
         if (op != sfcs_pkg::OP_TICK) begin
            cmd_op   = op;
            cmd_addr = addr;
            cmd_data = data;
            seg_now  = (op == sfcs_pkg::OP_READ) ? sfcs_pkg::SEG_HI : sfcs_pkg::SEG_WEN_HI;
            if (op == sfcs_pkg::OP_PROGRAM) programs_started++;
            if (op == sfcs_pkg::OP_ERASE) erases_started++;
         end
      end else if (op != sfcs_pkg::OP_TICK) begin
         r.rejected = 1'b1;
         rejects_seen++;
      end

      case (seg_now)
         sfcs_pkg::SEG_WEN_HI: seg_now = sfcs_pkg::SEG_WEN_LO;
         sfcs_pkg::SEG_HI:     seg_now = sfcs_pkg::SEG_LO;
         sfcs_pkg::SEG_WEN_LO, sfcs_pkg::SEG_LO: begin
            r.chip_select_n = 1'b0;
            bit_phase = '0;
            bit_no    = '0;
            byte_no   = '0;
            tx_byte   = (seg_now == sfcs_pkg::SEG_LO) ? frame_byte(3'd0)
                                                      : sfcs_pkg::CMD_WRITE_ENABLE;
            seg_now   = (seg_now == sfcs_pkg::SEG_LO) ? sfcs_pkg::SEG_BITS
                                                      : sfcs_pkg::SEG_WEN_BITS;
         end
         sfcs_pkg::SEG_WEN_BITS, sfcs_pkg::SEG_BITS: begin
            r.chip_select_n = 1'b0;
            n_bytes = (seg_now == sfcs_pkg::SEG_WEN_BITS) ? 1 :
                      1 + FLASH_ADDR_BYTES + ((cmd_op == sfcs_pkg::OP_ERASE) ? 0 : 1);
            r.mosi = tx_byte[3'd7 - bit_no];
            r.sclk = (bit_phase == 2'd1);
            if (bit_phase == 2'd1) rx_byte = {rx_byte[6:0], miso};
            if (bit_phase < 2'd2) begin
               bit_phase++;
            end else begin
               bit_phase = '0;
               if (bit_no < 3'd7) begin
                  bit_no++;
               end else begin
                  bit_no = '0;
                  byte_no++;
                  if (byte_no >= n_bytes)
                     seg_now = (seg_now == sfcs_pkg::SEG_BITS) ? sfcs_pkg::SEG_END
                                                               : sfcs_pkg::SEG_WEN_END;
                  else
                     tx_byte = (seg_now == sfcs_pkg::SEG_BITS) ? frame_byte(byte_no)
                                                               : sfcs_pkg::CMD_WRITE_ENABLE;
               end
            end
         end
         sfcs_pkg::SEG_WEN_END: seg_now = sfcs_pkg::SEG_HI;
         sfcs_pkg::SEG_END: begin
            if (cmd_op == sfcs_pkg::OP_READ) begin
               r.read_valid = 1'b1;
               r.read_data  = rx_byte;
               reads_done++;
               seg_now = sfcs_pkg::SEG_IDLE;
            end else begin
               // wait registers are sampled here, at the closing phase
               w = (cmd_op == sfcs_pkg::OP_PROGRAM) ? 24'(cfg_program_wait) : cfg_erase_wait;
               if (w == 0) begin
                  seg_now = sfcs_pkg::SEG_IDLE;
               end else begin
                  wait_left = w;
                  seg_now = sfcs_pkg::SEG_WAIT;
               end
            end
         end
         sfcs_pkg::SEG_WAIT: begin
            if (wait_left > 0) wait_left--;
            if (wait_left == 0) seg_now = sfcs_pkg::SEG_IDLE;
         end
         default: r.busy_res = 1'b0;
      endcase
      return r;
   endfunction

   // Phases a command keeps the sequencer busy, counting its accepting phase
   function automatic int unsigned busy_span(logic [1:0] op, int unsigned wait_phases);
      int unsigned frame;
      frame = 3 + 24 * (1 + FLASH_ADDR_BYTES + ((op == sfcs_pkg::OP_ERASE) ? 0 : 1));
      if (op == sfcs_pkg::OP_READ) return frame;
      return 27 + frame + wait_phases;
   endfunction

   function automatic int unsigned current_wait(logic [1:0] op);
      if (op == sfcs_pkg::OP_PROGRAM) return cfg_program_wait;
      if (op == sfcs_pkg::OP_ERASE) return cfg_erase_wait;
      return 0;
   endfunction

   // miso_sel: 0 or 1 hold miso at that level, 2 draws it at random
   task automatic queue_phase(logic [1:0] op, logic [23:0] addr, logic [7:0] data,
                              int unsigned miso_sel);
      phase_item_type it;
      it.op   = op;
      it.addr = addr;
      it.data = data;
      it.miso = (miso_sel == 2) ? 1'($urandom_range(0, 1)) : 1'(miso_sel);
      pending_phases.push_back(it);
   endtask

   // Idle ticks; noise_pct of them carry a command meant to be rejected
   task automatic queue_ticks(int unsigned n, int unsigned noise_pct, int unsigned miso_sel);
      logic [1:0] op;
      repeat (n) begin
         op = ($urandom_range(0, 99) < noise_pct) ? 2'($urandom_range(1, 3))
                                                  : sfcs_pkg::OP_TICK;
         queue_phase(op, 24'($urandom), 8'($urandom), miso_sel);
      end
   endtask

   // A command, ticks over its whole busy span, then extra idle ticks
   task automatic queue_command(logic [1:0] op, logic [23:0] addr, logic [7:0] data,
                                int unsigned noise_pct, int unsigned extra,
                                int unsigned miso_sel);
      queue_phase(op, addr, data, miso_sel);
      queue_ticks(busy_span(op, current_wait(op)) - 1, noise_pct, miso_sel);
      queue_ticks(extra, 0, 2);
   endtask

   // Hold until every queued phase has transferred and every response arrived
   task automatic settle();
      @(posedge clock);
      while (pending_phases.size() != 0 || req_tvalid || expected_pins.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(logic [sfcs_pkg::CSR_INDEX_W-1:0] reg_index, logic [23:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= value;
      if (reg_index == sfcs_pkg::CSR_PROGRAM_WAIT) cfg_program_wait = value[15:0];
      else cfg_erase_wait = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic check_field(string label, logic [7:0] exp_val, logic [7:0] act_val);
      if (exp_val !== act_val) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, exp_val, act_val);
      end
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Drive request transfers in bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_done) begin
         req_done = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_phases.size() > 0) begin
            next_item = pending_phases.pop_front();
            req_tuser  <= next_item.op;
            req_tdata  <= {7'd0, next_item.miso, next_item.data, next_item.addr};
            req_tvalid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                         : $urandom_range(1, 30);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Stall the response side on a rotating 16-bit pattern, redrawn at random
   always @(negedge clock) begin
      if (stall_age == 0) begin
         stall_age = 32;
         stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
      end
      stall_age--;
      rsp_tready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
   end

   // Predict on each request transfer, check each response transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_pins.push_back(advance_phase(req_tuser, req_tdata[23:0],
                                                  req_tdata[31:24], req_tdata[32]));
            req_done = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pins.size() == 0) begin
               mismatch_count++;
               $display("%0t: response with nothing expected, actual tdata %0h tuser %0h",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = expected_pins.pop_front();
               check_field("chip_select_n", 8'(want.chip_select_n), 8'(rsp_tdata[0]));
               check_field("mosi", 8'(want.mosi), 8'(rsp_tdata[1]));
               check_field("sclk", 8'(want.sclk), 8'(rsp_tdata[2]));
               check_field("busy_res", 8'(want.busy_res), 8'(rsp_tdata[3]));
               check_field("read_data", want.read_data, rsp_tdata[11:4]);
               check_field("rejected", 8'(want.rejected), 8'(rsp_tdata[12]));
               check_field("read_valid", 8'(want.read_valid), 8'(rsp_tuser[0]));
            end
         end
      end
   end

   // Stimulus
   initial begin
      logic [1:0]  op;
      logic [23:0] addr;
      int unsigned mark;
      int unsigned span;
      int unsigned split;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: idle pins, a read of all-ones data at the top address with
      // commands while busy, a program under the reset wait
      queue_ticks(6, 0, 2);
      queue_command(sfcs_pkg::OP_READ, 24'hffffff, 8'hff, 20, 2, 1);
      queue_command(sfcs_pkg::OP_PROGRAM, 24'h123456, 8'hff, 10, 2, 2);
      settle();

      // Zero waits: idle right after the closing phase
      write_csr(sfcs_pkg::CSR_PROGRAM_WAIT, 24'd0);
      write_csr(sfcs_pkg::CSR_ERASE_WAIT, 24'd0);
      queue_command(sfcs_pkg::OP_PROGRAM, 24'h000000, 8'h5a, 0, 0, 2);
      queue_command(sfcs_pkg::OP_ERASE, 24'hffffff, 8'ha5, 15, 2, 2);
      settle();

      // Erase wait at its maximum, rewritten while the erase is still shifting
      write_csr(sfcs_pkg::CSR_ERASE_WAIT, 24'hffffff);
      queue_phase(sfcs_pkg::OP_ERASE, 24'h800000, 8'h00, 2);
      queue_ticks(40, 10, 2);
      settle();
      write_csr(sfcs_pkg::CSR_ERASE_WAIT, 24'd7);
      queue_ticks(busy_span(sfcs_pkg::OP_ERASE, 7) - 41, 10, 2);
      queue_ticks(3, 0, 2);
      settle();

      // Program wait written with bits above its width, which drop
      write_csr(sfcs_pkg::CSR_PROGRAM_WAIT, 24'hff0003);
      queue_command(sfcs_pkg::OP_PROGRAM, 24'($urandom), 8'($urandom), 2, 2, 2);
      settle();

      // Random rounds under fresh wait settings
      for (int round = 0; round < RANDOM_ROUNDS; round++) begin
         write_csr(sfcs_pkg::CSR_PROGRAM_WAIT,
                   (round == 0) ? 24'd1 : 24'($urandom_range(0, 40)));
         write_csr(sfcs_pkg::CSR_ERASE_WAIT,
                   (round == 0) ? 24'd2 : 24'($urandom_range(0, 40)));
         mark = phases_run + pending_phases.size();
         while (phases_run + pending_phases.size() - mark < ROUND_PHASES) begin
            op = 2'($urandom_range(1, 3));
            case ($urandom_range(0, 7))
               0:       addr = 24'h000000;
               1:       addr = 24'hffffff;
               default: addr = 24'($urandom);
            endcase
            if ($urandom_range(0, 9) == 0) begin
               // second command lands in the middle of the first
               span  = busy_span(op, current_wait(op));
               split = $urandom_range(1, span - 2);
               queue_phase(op, addr, 8'($urandom), 2);
               queue_ticks(split, 0, 2);
               queue_phase(2'($urandom_range(1, 3)), 24'($urandom), 8'($urandom), 2);
               queue_ticks(span - 2 - split, 0, 2);
               queue_ticks($urandom_range(0, 4), 0, 2);
            end else begin
               queue_command(op, addr, 8'($urandom), 4,
                             ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6), 2);
            end
         end
         settle();
      end

      repeat (10) @(posedge clock);
      if (expected_pins.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d responses never arrived", $time, expected_pins.size());
      end
      $display("Ran %0d phases: %0d reads completed, %0d programs, %0d erases started,",
               phases_run, reads_done, programs_started, erases_started);
      $display("%0d commands rejected while busy, %0d field mismatches",
               rejects_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #100_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/sfcs_pkg.sv
rtl/sfcs_engine.sv
rtl/sfcs_rsp_stage.sv
rtl/spi_flash_command_sequencer.sv
bench/tb.sv
